>>> hw/rtl/ile_pkg.sv
package ile_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_WRITE  = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [POS_W-1:0]    pos;
		logic [DATA_W-1:0]   value;
	} cell_ctl_t;

endpackage

>>> hw/rtl/ile_req_if.sv
interface ile_req_if import ile_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  pos;
	logic [DATA_W-1:0] value;

	modport source (output valid, output func, output pos, output value, input ready);
	modport sink (input valid, input func, input pos, input value, output ready);
endinterface

>>> hw/rtl/ile_rsp_if.sv
interface ile_rsp_if import ile_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_value;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    count;
	logic                is_empty;

	modport source (output valid, output read_value, output status, output count,
		output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input count,
		input is_empty, output ready);
endinterface

>>> hw/rtl/indexed_list_engine.sv
// Ordered list of up to 16 words of 32 bits held in a row of 16 cells. Each request
// (insert, remove, overwrite or read at a position) is applied to all cells at once in
// the cycle the item is accepted, each cell taking its own word, the request word, its
// lower neighbor's or its upper neighbor's; the result appears in the output register
// on the next cycle. One item per clock is sustained: the input is ready whenever the
// output register is empty or its result is being taken in the same cycle. Rejected
// requests (bad position, insert into a full list) leave the cells untouched.
module indexed_list_engine import ile_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ile_req_if.sink   in_ch,
	ile_rsp_if.source out_ch
);

	logic [DATA_W-1:0]   cell_data [CAPACITY];
	cell_ctl_t           ctl;
	logic                accept;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	status_t             status_d;
	logic [DATA_W-1:0]   rd_d;
	cell_op_t            op_d;

	logic                out_valid_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    out_count_q;
	logic                is_empty_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		rd_d     = '0;
		op_d     = CELL_HOLD;
		case (in_ch.func)
			FUNC_INSERT: begin
				if (in_ch.pos > count_q) begin
					status_d = ST_BADPOS;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INSERT;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			FUNC_REMOVE: begin
				if (in_ch.pos >= count_q) begin
					status_d = ST_BADPOS;
				end else begin
					op_d    = CELL_REMOVE;
					count_d = CNT_W'(count_q - 1'b1);
				end
			end
			FUNC_WRITE: begin
				if (in_ch.pos >= count_q) begin
					status_d = ST_BADPOS;
				end else begin
					op_d = CELL_WRITE;
				end
			end
			FUNC_READ: begin
				if (in_ch.pos >= count_q) begin
					status_d = ST_BADPOS;
				end else begin
					// a valid position is below the count, so the low bits address a cell
					rd_d = cell_data[in_ch.pos[IDX_W-1:0]];
				end
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	assign ctl.op    = accept ? op_d : CELL_HOLD;
	assign ctl.pos   = in_ch.pos;
	assign ctl.value = in_ch.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		ile_cell u_cell (
			.clk   (clk),
			.idx   (POS_W'(i)),
			.ctl   (ctl),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_d;
			status_q     <= status_d;
			out_count_q  <= count_d;
			is_empty_q   <= (count_d == '0);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_value = read_value_q;
	assign out_ch.status     = status_q;
	assign out_ch.count      = out_count_q;
	assign out_ch.is_empty   = is_empty_q;

endmodule

>>> hw/rtl/ile_cell.sv
module ile_cell import ile_pkg::*; (
	input  logic              clk,
	input  logic [POS_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				// cells above the insert point take their lower neighbor
				if (idx > ctl.pos) begin
					data_q <= left;
				end else if (idx == ctl.pos) begin
					data_q <= ctl.value;
				end
			end
			CELL_REMOVE: begin
				if (idx >= ctl.pos) begin
					data_q <= right;
				end
			end
			CELL_WRITE: begin
				if (idx == ctl.pos) begin
					data_q <= ctl.value;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

>>> tb/sv/indexed_list_engine_test.sv
`timescale 1ns / 100ps

module indexed_list_engine_test import ile_pkg::*;;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
	} list_reply_t;

	localparam int RAND_BLOCKS = 15;
	localparam int BLOCK_ITEMS = 100;
	localparam int DRAIN_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	ile_req_if req_ch();
	ile_rsp_if rsp_ch();

	indexed_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (rsp_ch)
	);

	// mirror of the list contents, index 0 is the head
	logic [DATA_W-1:0] list_words[$];
	list_reply_t       pending_replies[$];

	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int rx_hold    = 0;

	int op_seen[4];
	int badpos_hits  = 0;
	int full_hits    = 0;
	int peak_count   = 0;
	int replies_seen = 0;
	int failures     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_reply_t apply_list_op(func_t op, logic [POS_W-1:0] where,
			logic [DATA_W-1:0] word);
		list_reply_t r;
		int n;
		n = list_words.size();
		r.read_value = '0;
		r.status = ST_DONE;
		if (op == FUNC_INSERT) begin
			// a bad position wins over a full list
			if (where > n) begin
				r.status = ST_BADPOS;
			end else if (n >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				list_words.insert(where, word);
			end
		end else if (where >= n) begin
			r.status = ST_BADPOS;
		end else begin
			case (op)
				FUNC_REMOVE: list_words.delete(where);
				FUNC_WRITE:  list_words[where] = word;
				default:     r.read_value = list_words[where];
			endcase
		end
		if (r.status == ST_BADPOS) badpos_hits++;
		if (r.status == ST_FULL) full_hits++;
		if (list_words.size() > peak_count) peak_count = list_words.size();
		r.count = CNT_W'(list_words.size());
		r.is_empty = (list_words.size() == 0);
		return r;
	endfunction

	task automatic issue_request(input func_t op, input logic [POS_W-1:0] where,
			input logic [DATA_W-1:0] word);
		while (tx_gaps_on && $urandom_range(99) < 34) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= op;
		req_ch.pos   <= where;
		req_ch.value <= word;
		do @(posedge clk); while (!req_ch.ready);
		pending_replies.push_back(apply_list_op(op, where, word));
		op_seen[op]++;
	endtask

	// mostly legal positions for the current fill level, sometimes anything
	function automatic logic [POS_W-1:0] pick_pos(func_t op);
		int n;
		n = list_words.size();
		if ($urandom_range(9) == 0 || (op != FUNC_INSERT && n == 0))
			return POS_W'($urandom_range(31));
		if (op == FUNC_INSERT)
			return POS_W'($urandom_range(n));
		return POS_W'($urandom_range(n - 1));
	endfunction

	function automatic func_t pick_func(int ins_pct, int rem_pct);
		int r;
		r = $urandom_range(99);
		if (r < ins_pct) return FUNC_INSERT;
		if (r < ins_pct + rem_pct) return FUNC_REMOVE;
		return $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		issue_request(FUNC_READ, '0, 32'h1234_5678);
		issue_request(FUNC_REMOVE, POS_W'(31), '1);
		issue_request(FUNC_WRITE, '0, '1);
		issue_request(FUNC_INSERT, POS_W'(1), 32'hdead_beef);
	endtask

	task automatic test_fill_and_full();
		int k;
		k = 0;
		while (list_words.size() < CAPACITY) begin
			case (k % 3)
				0: issue_request(FUNC_INSERT, '0, (k == 0) ? '0 : $urandom);
				1: issue_request(FUNC_INSERT, POS_W'(list_words.size()), '1);
				default: issue_request(FUNC_INSERT, POS_W'(list_words.size() / 2), $urandom);
			endcase
			k++;
		end
		issue_request(FUNC_INSERT, POS_W'(CAPACITY), $urandom);
		issue_request(FUNC_INSERT, POS_W'(31), $urandom);
	endtask

	task automatic test_edge_positions();
		issue_request(FUNC_WRITE, POS_W'(CAPACITY - 1), '1);
		issue_request(FUNC_READ, POS_W'(CAPACITY - 1), '0);
		issue_request(FUNC_READ, POS_W'(CAPACITY), '0);
		issue_request(FUNC_REMOVE, POS_W'(CAPACITY - 1), '0);
		issue_request(FUNC_REMOVE, '0, '1);
	endtask

	// receiver holds off while the sender keeps pushing, so the input stalls
	task automatic test_backpressure();
		func_t op;
		tx_gaps_on = 1'b0;
		rx_hold = 60;
		repeat (30) begin
			op = pick_func(40, 30);
			issue_request(op, pick_pos(op), pick_word());
		end
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_mix();
		func_t op;
		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			tx_gaps_on = (blk != 7);
			rx_gaps_on = (blk != 7);
			repeat (BLOCK_ITEMS) begin
				// alternate between filling up and draining down
				if (blk % 2 == 0)
					op = pick_func(55, 20);
				else
					op = pick_func(20, 55);
				issue_request(op, pick_pos(op), pick_word());
			end
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				rsp_ch.ready <= !(rx_gaps_on && $urandom_range(99) < 34);
			end
		end
	end

	always @(posedge clk) begin
		list_reply_t want;
		list_reply_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_value = rsp_ch.read_value;
			got.status = status_t'(rsp_ch.status);
			got.count = rsp_ch.count;
			got.is_empty = rsp_ch.is_empty;
			replies_seen++;
			if (pending_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected reply: value %h status %0d count %0d empty %b",
						got.read_value, got.status, got.count, got.is_empty);
			end else begin
				want = pending_replies.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
						got.count !== want.count || got.is_empty !== want.is_empty) begin
					failures++;
					if (failures <= 10)
						$display("reply mismatch: expected %h %0d %0d %b, got %h %0d %0d %b",
							want.read_value, want.status, want.count, want.is_empty,
							got.read_value, got.status, got.count, got.is_empty);
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("timeout with %0d replies outstanding", pending_replies.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func  <= FUNC_INSERT;
		req_ch.pos   <= '0;
		req_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_and_full();
		test_edge_positions();
		test_backpressure();
		test_random_mix();
		req_ch.valid <= 1'b0;

		for (int k = 0; k < DRAIN_LIMIT && pending_replies.size() > 0; k++)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (pending_replies.size() != 0) begin
			failures++;
			$display("%0d replies never arrived", pending_replies.size());
		end

		$display("requests: %0d insert, %0d remove, %0d write, %0d read; %0d replies checked",
			op_seen[FUNC_INSERT], op_seen[FUNC_REMOVE], op_seen[FUNC_WRITE],
			op_seen[FUNC_READ], replies_seen);
		$display("bad position %0d, full list %0d, peak fill %0d, failures %0d",
			badpos_hits, full_hits, peak_count, failures);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
